// ----- sv/psm_pkg.sv -----
// Shared constants for the primary sample mutation block.
package psm_pkg;
   localparam int PSM_FRAC_BITS = 24;
   localparam int PSM_QUEUE_DEPTH = 4;
   localparam int PSM_CSR_ADDR_W = 3;
   localparam logic PSM_REG_MUTATION_RANGE = 1'b0;
   localparam logic PSM_MODE_PLAIN = 1'b0;
   localparam logic PSM_MODE_SCALED = 1'b1;
endpackage

// ----- sv/psm_req_if.sv -----
// Input channel carrying one sample and one random value per item.
interface psm_req_if #(parameter int FRAC_BITS = psm_pkg::PSM_FRAC_BITS);
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [FRAC_BITS-1:0] sample_value;
   logic [FRAC_BITS-1:0] random_value;
   modport source(output valid, req_type, sample_value, random_value, input ready);
   modport sink(input valid, req_type, sample_value, random_value, output ready);
endinterface

// ----- sv/psm_rsp_if.sv -----
// Result channel carrying one mutated sample per item.
interface psm_rsp_if #(parameter int FRAC_BITS = psm_pkg::PSM_FRAC_BITS);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS-1:0] mutated_value;
   modport source(output valid, mutated_value, input ready);
   modport sink(input valid, mutated_value, output ready);
endinterface

// ----- sv/psm_front.sv -----
// Front stage: accepts items and forms the divider operands of the mutation law.
module psm_front #(
   parameter int FRAC_BITS = psm_pkg::PSM_FRAC_BITS,
   parameter int EW = 1 + 2 * FRAC_BITS + (FRAC_BITS + 6) + (2 * FRAC_BITS + 2)
) (
   input  logic                 clock,
   input  logic                 reset,
   psm_req_if.sink              req_if,
   input  logic [FRAC_BITS-1:0] mutation_range,
   output logic                 push_valid,
   output logic [EW-1:0]        push_data,
   input  logic                 push_ready
);
   localparam int F = FRAC_BITS;
   localparam int DSW = F + 6;
   localparam int DW = 2 * F + 2;
   localparam longint unsigned ONE_L = 64'd1 << F;
   localparam logic [F-1:0] T2_PLAIN = F'((ONE_L + 64'd264) / 64'd528);
   localparam logic [F:0] ONE_W = {1'b1, {F{1'b0}}};

   logic          valid_ff, valid_in;
   logic [EW-1:0] data_ff;
   logic [F:0]    twice, a;
   logic [DSW-1:0] dsr, r33;
   logic [DW-1:0] num, dividend;
   logic [F:0]    t2_wide;
   logic [F-1:0]  t2;
   logic          up, take;

   assign take = req_if.valid && req_if.ready;
   assign req_if.ready = !valid_ff || push_ready;

   always_comb begin
      twice = {req_if.random_value, 1'b0};
      a = (twice >= ONE_W) ? (twice - ONE_W) : (ONE_W - twice);
      dsr = DSW'(ONE_W) + (DSW'(a) << 5);
      r33 = (DSW'(mutation_range) << 5) + DSW'(mutation_range);
      t2_wide = ({1'b0, mutation_range} + (F+1)'(16)) >> 5;
      if (req_if.req_type == psm_pkg::PSM_MODE_SCALED) begin
         num = DW'(r33) << (F - 5);
         t2 = t2_wide[F-1:0];
      end else begin
         num = DW'(1) << (2 * F - 4);
         t2 = T2_PLAIN;
      end
      dividend = num + DW'(dsr >> 1);
      up = !req_if.random_value[F-1];
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= {up, req_if.sample_value, t2, dsr, dividend};
      end
   end

   assign push_valid = valid_ff;
   assign push_data = data_ff;
endmodule

// ----- sv/psm_queue.sv -----
// Short queue between the front stage and the divider pipeline.
module psm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = psm_pkg::PSM_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count exceeds depth");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("pop from empty queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> count_ff != CW'(DEPTH)) else $error("push into full queue");
endmodule

// ----- sv/psm_back.sv -----
// Back end: pipelined restoring divider, step correction and wrapped add or subtract.
module psm_back #(
   parameter int FRAC_BITS = psm_pkg::PSM_FRAC_BITS,
   parameter int EW = 1 + 2 * FRAC_BITS + (FRAC_BITS + 6) + (2 * FRAC_BITS + 2)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  logic [EW-1:0] q_data,
   output logic          q_pop,
   psm_rsp_if.source     rsp_if
);
   localparam int F = FRAC_BITS;
   localparam int DSW = F + 6;
   localparam int DW = 2 * F + 2;
   localparam int QW = F + 1;

   logic           adv;
   logic           valid_ff [QW+1];
   logic [DSW-1:0] rem_ff [QW+1];
   logic [QW-1:0]  low_ff [QW+1];
   logic [QW-1:0]  quo_ff [QW+1];
   logic [DSW-1:0] dsr_ff [QW+1];
   logic [F-1:0]   x_ff [QW+1];
   logic [F-1:0]   t2_ff [QW+1];
   logic           up_ff [QW+1];
   logic           rsp_valid_ff;
   logic [F-1:0]   rsp_data_ff, rsp_data_in;
   logic [DW-1:0]  ld_dividend;
   logic [QW-1:0]  dx_full;
   logic [F-1:0]   dx;

   assign adv = !rsp_valid_ff || rsp_if.ready;
   assign q_pop = adv && q_valid;
   assign ld_dividend = q_data[DW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rem_ff[0] <= DSW'(ld_dividend[DW-1:QW]);
         low_ff[0] <= ld_dividend[QW-1:0];
         quo_ff[0] <= '0;
         dsr_ff[0] <= q_data[DW+DSW-1:DW];
         t2_ff[0] <= q_data[DW+DSW+F-1:DW+DSW];
         x_ff[0] <= q_data[DW+DSW+2*F-1:DW+DSW+F];
         up_ff[0] <= q_data[EW-1];
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [DSW:0]   trial;
      logic           ge;
      logic [DSW-1:0] rem_in;

      always_comb begin
         trial = {rem_ff[k-1], low_ff[k-1][QW-1]};
         ge = trial >= {1'b0, dsr_ff[k-1]};
         rem_in = ge ? DSW'(trial - {1'b0, dsr_ff[k-1]}) : DSW'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_ff[k-1] << 1;
            quo_ff[k] <= {quo_ff[k-1][QW-2:0], ge};
            dsr_ff[k] <= dsr_ff[k-1];
            x_ff[k] <= x_ff[k-1];
            t2_ff[k] <= t2_ff[k-1];
            up_ff[k] <= up_ff[k-1];
         end
      end

      a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
         valid_ff[k] |-> rem_ff[k] < dsr_ff[k]) else $error("partial remainder too large");
   end

   always_comb begin
      dx_full = (quo_ff[QW] > {1'b0, t2_ff[QW]}) ? (quo_ff[QW] - {1'b0, t2_ff[QW]}) : '0;
      dx = dx_full[F-1:0];
      rsp_data_in = up_ff[QW] ? (x_ff[QW] + dx) : (x_ff[QW] - dx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.mutated_value = rsp_data_ff;

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop without queued item");
   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff[QW])) else $error("pipeline moved during stall");
endmodule

// ----- sv/primary_sample_mutation.sv -----
// Top level of the primary sample mutation block with its register port.
// An accepted item passes the front register, queue, divider stages and output register.
// Throughput: one item per cycle while rsp_if is ready; one quotient bit per divider stage.
// A four-entry queue decouples the front stage from the divider, so either side stalls alone.
// Reset is synchronous and active high; it empties all stages and the queue.
// After reset, mutation_range holds 0.1 in fraction form (1677722 at 24 bits).
module primary_sample_mutation #(
   parameter int FRAC_BITS = psm_pkg::PSM_FRAC_BITS,
   parameter int QUEUE_DEPTH = psm_pkg::PSM_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   psm_req_if.sink                            req_if,
   psm_rsp_if.source                          rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [psm_pkg::PSM_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   localparam int F = FRAC_BITS;
   localparam int EW = 1 + 2 * F + (F + 6) + (2 * F + 2);
   localparam longint unsigned ONE_L = 64'd1 << F;
   localparam logic [F-1:0] RANGE_RESET = F'((ONE_L + 64'd5) / 64'd10);

   logic [F-1:0]  range_ff, range_in;
   logic          reg_hit;
   logic          push_valid, push_ready, q_valid, q_pop;
   logic [EW-1:0] push_data, q_data;

   assign reg_hit = (csr_paddr[psm_pkg::PSM_CSR_ADDR_W-1:2] == psm_pkg::PSM_REG_MUTATION_RANGE);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? 32'(range_ff) : '0;

   always_comb begin
      range_in = range_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         range_in = csr_pwdata[F-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= RANGE_RESET;
      end else begin
         range_ff <= range_in;
      end
   end

   psm_front #(.FRAC_BITS(F), .EW(EW)) u_front (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .mutation_range(range_ff),
      .push_valid(push_valid),
      .push_data(push_data),
      .push_ready(push_ready)
   );

   psm_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push_valid && push_ready),
      .push_data(push_data),
      .push_ready(push_ready),
      .pop(q_pop),
      .pop_valid(q_valid),
      .pop_data(q_data)
   );

   psm_back #(.FRAC_BITS(F), .EW(EW)) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_data(q_data),
      .q_pop(q_pop),
      .rsp_if(rsp_if)
   );
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the primary sample mutation block.
`timescale 1ns / 100ps

module tb_top;
   localparam int FB = psm_pkg::PSM_FRAC_BITS;
   localparam int AW = psm_pkg::PSM_CSR_ADDR_W;
   localparam logic [63:0] ONE = 64'd1 << FB;
   localparam logic [63:0] MASK = ONE - 64'd1;
   localparam logic [FB-1:0] RANGE_RESET = FB'((ONE + 64'd5) / 64'd10);
   localparam logic [AW-1:0] RANGE_ADDR = AW'(4 * psm_pkg::PSM_REG_MUTATION_RANGE);
   localparam logic [AW-1:0] UNUSED_ADDR = AW'(4);
   localparam int DRAIN_CYCLES = FB + 16;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic          mode;
      logic [FB-1:0] x;
      logic [FB-1:0] u;
   } sample_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [AW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   psm_req_if req_ch();
   psm_rsp_if rsp_ch();

   primary_sample_mutation uut (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   sample_item_type pending_items[$];
   logic [FB-1:0] expected_values[$];
   logic [FB-1:0] range_mirror = RANGE_RESET;
   int  fail_count = 0;
   int  results_seen = 0;
   int  idle_cycles = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   bit  no_idle = 0;
   bit  req_taken = 0;
   bit  rsp_taken = 0;
   int  gap_left = 0;
   int  stall_left = 0;

   always #6 clock = ~clock;

   function automatic logic [63:0] mutation_step(logic mode, logic [FB-1:0] u,
                                                 logic [FB-1:0] r);
      logic [63:0]  twice, a, t2, dx;
      logic [127:0] num, den, t1;
      twice = 64'({u, 1'b0});
      a = (twice >= ONE) ? twice - ONE : ONE - twice;
      if (mode == psm_pkg::PSM_MODE_SCALED) begin
         den = 128'(32 * (ONE + 32 * a));
         num = (128'(33 * 64'(r)) << FB) + (den >> 1);
         t2 = (64'(r) + 64'd16) >> 5;
      end else begin
         den = 128'(ONE + 32 * a);
         num = (128'd1 << (2 * FB - 4)) + (den >> 1);
         t2 = (ONE + 64'd264) / 64'd528;
      end
      t1 = num / den;
      dx = (t1 > 128'(t2)) ? 64'(t1) - t2 : 64'd0;
      return dx & MASK;
   endfunction

   function automatic logic [FB-1:0] mutate_sample(sample_item_type it, logic [FB-1:0] r);
      logic [63:0] dx, x, y;
      dx = mutation_step(it.mode, it.u, r);
      x = 64'(it.x);
      if (64'(it.u) < (ONE >> 1)) begin
         y = x + dx;
         if (y >= ONE) y = y - ONE;
      end else begin
         y = (x >= dx) ? x - dx : x + ONE - dx;
      end
      return FB'(y);
   endfunction

   task automatic report(string what, logic [FB-1:0] got, logic [FB-1:0] want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 16);
   endfunction

   // Acceptance, expectation, checking, pressure and watchdog.
   always @(posedge clock) begin
      req_taken = !reset && req_ch.valid && req_ch.ready;
      rsp_taken = !reset && rsp_ch.valid && rsp_ch.ready;
      if (req_taken)
         expected_values.push_back(mutate_sample({req_ch.req_type, req_ch.sample_value,
                                                  req_ch.random_value}, range_mirror));
      if (rsp_taken) begin
         results_seen++;
         if (expected_values.size() == 0)
            report("unexpected item", rsp_ch.mutated_value, '0);
         else if (rsp_ch.mutated_value !== expected_values[0])
            report("mutated_value", rsp_ch.mutated_value, expected_values.pop_front());
         else
            void'(expected_values.pop_front());
      end
      if (hold_left > 0)
         hold_left <= hold_left - 1;
      else if (!hold_done && results_seen == 200) begin
         hold_left <= 300;
         hold_done <= 1;
      end
      if (req_taken || rsp_taken || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      sample_item_type it;
      if (reset)
         req_ch.valid <= 1'b0;
      else if (req_ch.valid && !req_taken) begin
      end else if (gap_left > 0) begin
         gap_left--;
         req_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
         it = pending_items.pop_front();
         req_ch.req_type <= it.mode;
         req_ch.sample_value <= it.x;
         req_ch.random_value <= it.u;
         req_ch.valid <= 1'b1;
         gap_left = draw_wait();
      end else
         req_ch.valid <= 1'b0;
   end

   always @(negedge clock) begin
      if (rsp_taken)
         stall_left = draw_wait();
      if (reset || hold_left > 0)
         rsp_ch.ready <= 1'b0;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else
         rsp_ch.ready <= 1'b1;
   end

   task automatic csr_write(logic [AW-1:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (addr == RANGE_ADDR)
         range_mirror = data[FB-1:0];
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_ch.valid || expected_values.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [FB-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return FB'(ONE >> 1);
         3: return FB'((ONE >> 1) - 1);
         default: return FB'($urandom);
      endcase
   endfunction

   task automatic add_random(int count);
      sample_item_type it;
      repeat (count) begin
         it.mode = $urandom_range(0, 1) ? psm_pkg::PSM_MODE_SCALED : psm_pkg::PSM_MODE_PLAIN;
         it.x = pick_value();
         it.u = pick_value();
         pending_items.push_back(it);
      end
   endtask

   task automatic add_directed();
      sample_item_type it;
      logic [FB-1:0] u_list[6] = '{'0, FB'(1), FB'(ONE >> 1), FB'((ONE >> 1) - 1), '1,
                                    FB'(ONE >> 3)};
      for (int m = 0; m < 2; m++) begin
         foreach (u_list[i]) begin
            it.mode = m[0] ? psm_pkg::PSM_MODE_SCALED : psm_pkg::PSM_MODE_PLAIN;
            it.u = u_list[i];
            it.x = i[0] ? '1 : '0;
            pending_items.push_back(it);
         end
         // Unless the step is zero, the sum lands exactly on one and must wrap to zero.
         it.u = FB'(ONE >> 3);
         it.x = FB'(ONE - mutation_step(it.mode, it.u, range_mirror));
         pending_items.push_back(it);
      end
   endtask

   initial begin
      logic [31:0] ranges[4];
      req_ch.valid = 1'b0;
      req_ch.req_type = psm_pkg::PSM_MODE_PLAIN;
      req_ch.sample_value = '0;
      req_ch.random_value = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      add_directed();
      add_random(300);
      wait_idle();

      ranges = '{32'h0, 32'hFF_FFFFFF, $urandom, 32'(RANGE_RESET)};
      foreach (ranges[i]) begin
         csr_write(RANGE_ADDR, ranges[i]);
         // A write to an unused address must leave the range untouched.
         csr_write(UNUSED_ADDR, $urandom);
         no_idle = (i == 1);
         add_directed();
         add_random(280);
         wait_idle();
      end

      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule

// ----- filelist.f -----
sv/psm_pkg.sv
sv/psm_req_if.sv
sv/psm_rsp_if.sv
sv/psm_front.sv
sv/psm_queue.sv
sv/psm_back.sv
sv/primary_sample_mutation.sv
sim/tb_top.sv
